// ===== rtl/ttl_keyed_peer_record_store_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the keyed peer record store
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TTL_KEYED_PEER_RECORD_STORE_MACROS_SVH
`define TTL_KEYED_PEER_RECORD_STORE_MACROS_SVH

// Check a property at every rising edge outside reset
`define TKPRS_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition never holds
`define TKPRS_NEVER(lbl, cond, msg) \
    `TKPRS_ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== rtl/tkprs_pkg.sv =====
// ----------------------------------------------------------------------------
// tkprs_pkg
// Transaction types, operation codes and status codes of the record store.
// ----------------------------------------------------------------------------
`default_nettype none

package tkprs_pkg;

    localparam int TOTAL_W = 11;

    // Operation codes
    localparam logic [1:0] FN_PUT    = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_GET    = 2'd2;
    localparam logic [1:0] FN_GC     = 2'd3;

    // Status codes
    localparam logic [3:0] ST_APPENDED  = 4'd0;
    localparam logic [3:0] ST_REPLACED  = 4'd1;
    localparam logic [3:0] ST_EVICTED   = 4'd2;
    localparam logic [3:0] ST_DROPPED   = 4'd3;
    localparam logic [3:0] ST_REMOVED   = 4'd4;
    localparam logic [3:0] ST_NOT_FOUND = 4'd5;
    localparam logic [3:0] ST_ENTRY     = 4'd6;
    localparam logic [3:0] ST_EMPTY     = 4'd7;
    localparam logic [3:0] ST_GC_DONE   = 4'd8;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] key_w0;
        logic [63:0] key_w1;
        logic [63:0] key_w2;
        logic [63:0] key_w3;
        logic [31:0] peer_host;
        logic [15:0] peer_port;
        logic [63:0] created_ms;
        logic [31:0] ttl_ms;
        logic [31:0] payload;
        logic [63:0] now_ms;
    } t_req;

    typedef struct packed {
        logic [3:0]         status;
        logic [31:0]        out_host;
        logic [15:0]        out_port;
        logic [63:0]        out_created_ms;
        logic [31:0]        out_ttl_ms;
        logic [31:0]        out_payload;
        logic               last;
        logic [TOTAL_W-1:0] total_records;
    } t_rsp;

    // One stored peer record
    typedef struct packed {
        logic [31:0] host;
        logic [15:0] port;
        logic [63:0] created;
        logic [31:0] ttl;
        logic [31:0] payload;
    } t_rec;

endpackage

`default_nettype wire

// ===== rtl/tkprs_if.sv =====
// ----------------------------------------------------------------------------
// tkprs_if
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface tkprs_req_if;
    logic             valid;
    logic             ready;
    tkprs_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tkprs_rsp_if;
    logic             valid;
    logic             ready;
    tkprs_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ttl_keyed_peer_record_store.sv =====
// Lookup: the key search scans the slots in order until a hit, then put/remove
//   read every stored record of the slot; get hands the records out one at a time.
// Flow: one transaction at a time; gc walks every slot and, for each valid slot,
//   reads every record and then closes the list.
// Reset: synchronous; a clearing pass over all TARGET_SLOTS slots marks them
//   free, and no request is taken until it ends.
// ----------------------------------------------------------------------------
// ttl_keyed_peer_record_store
// Keyed table of peer record lists with replace, oldest eviction and expiry.
// ----------------------------------------------------------------------------
`default_nettype none

module ttl_keyed_peer_record_store #(
    parameter int TARGET_SLOTS     = 64,
    parameter int PEERS_PER_TARGET = 20
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    tkprs_req_if.sink     i_req,
    tkprs_rsp_if.source   o_rsp
);

`include "ttl_keyed_peer_record_store_macros.svh"

    localparam int REC_DEPTH = TARGET_SLOTS * PEERS_PER_TARGET;
    localparam int SIW = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
    localparam int SCW = $clog2(TARGET_SLOTS + 1);
    localparam int CW  = $clog2(PEERS_PER_TARGET + 1);
    localparam int RAW = (REC_DEPTH > 1) ? $clog2(REC_DEPTH) : 1;
    localparam int BW  = RAW + 8;
    localparam int TW  = tkprs_pkg::TOTAL_W;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_DISP = 4'd3;
    localparam logic [3:0] S_RRD  = 4'd4;
    localparam logic [3:0] S_RCHK = 4'd5;
    localparam logic [3:0] S_PUTW = 4'd6;
    localparam logic [3:0] S_SLOTW = 4'd7;
    localparam logic [3:0] S_GRD  = 4'd8;
    localparam logic [3:0] S_GOUT = 4'd9;
    localparam logic [3:0] S_CRD  = 4'd10;
    localparam logic [3:0] S_CCHK = 4'd11;
    localparam logic [3:0] S_EMIT = 4'd12;

    typedef struct packed {
        logic          vld;
        logic [CW-1:0] cnt;
        logic [255:0]  key;
    } t_slot;

    // Memories
    t_slot            r_slot_mem [TARGET_SLOTS];
    t_slot            r_slot_q;
    tkprs_pkg::t_rec  r_rec_mem [REC_DEPTH];
    tkprs_pkg::t_rec  r_rec_q;

    // Control and working registers
    logic [3:0]       r_state;
    tkprs_pkg::t_req  r_in;
    logic [SCW-1:0]   r_sidx;
    logic             r_pv;
    logic [SIW-1:0]   r_pidx;
    logic             r_found;
    logic             r_free_ok;
    logic [SIW-1:0]   r_free;
    logic [SIW-1:0]   r_slot;
    logic [255:0]     r_key;
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_i;
    logic [CW-1:0]    r_w;
    logic [RAW-1:0]   r_base;
    logic             r_match_ok;
    logic [CW-1:0]    r_match;
    logic [CW-1:0]    r_old;
    logic [63:0]      r_old_t;
    logic [3:0]       r_status;
    logic [TW-1:0]    r_total;

    // Memory ports
    logic             slot_we;
    logic [SIW-1:0]   slot_waddr;
    t_slot            slot_wdata;
    logic [SIW-1:0]   slot_raddr;
    logic             rec_we;
    logic [RAW-1:0]   rec_waddr;
    tkprs_pkg::t_rec  rec_wdata;
    logic [RAW-1:0]   rec_raddr;

    logic             rsp_load;
    logic             rsp_free;
    tkprs_pkg::t_rsp  rsp_data;

    logic [255:0]     in_key;
    logic             slot_hit;
    logic             rec_match;
    logic             rec_drop;
    logic             rec_full;
    logic [CW-1:0]    put_idx;
    logic [SIW-1:0]   mult_src;
    logic [RAW-1:0]   base_nxt;
    logic [SIW-1:0]   sidx_lo;
    logic             sidx_last;

    assign in_key    = {r_in.key_w3, r_in.key_w2, r_in.key_w1, r_in.key_w0};
    assign slot_hit  = r_slot_q.vld && (r_slot_q.key == in_key);
    assign rec_match = (r_rec_q.host == r_in.peer_host) && (r_rec_q.port == r_in.peer_port);
    assign rec_drop  = (r_in.func == tkprs_pkg::FN_GC)
                     ? ((r_in.now_ms >= r_rec_q.created) &&
                        ((r_in.now_ms - r_rec_q.created) > {32'd0, r_rec_q.ttl}))
                     : rec_match;
    assign rec_full  = (r_n >= CW'(PEERS_PER_TARGET));
    assign put_idx   = r_match_ok ? r_match : (rec_full ? r_old : r_n);
    assign sidx_lo   = r_sidx[SIW-1:0];
    assign sidx_last = (r_sidx == SCW'(TARGET_SLOTS - 1));

    // Pick the slot whose record base is formed next
    always_comb begin
        case (r_state)
            S_CCHK:  mult_src = sidx_lo;
            default: mult_src = r_found ? r_slot : r_free;
        endcase
    end
    assign base_nxt = RAW'(BW'(mult_src) * BW'(PEERS_PER_TARGET));

    assign i_req.ready = (r_state == S_IDLE);

    // Memory port control
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_slot;
        slot_wdata = '{vld: 1'b0, cnt: '0, key: r_key};
        slot_raddr = sidx_lo;
        rec_we     = 1'b0;
        rec_waddr  = r_base + RAW'(r_w);
        rec_wdata  = r_rec_q;
        rec_raddr  = r_base + RAW'(r_i);
        case (r_state)
            S_CLR: begin
                slot_we    = 1'b1;
                slot_waddr = sidx_lo;
            end
            S_SCAN: begin
                if (r_sidx >= SCW'(TARGET_SLOTS)) begin
                    slot_raddr = '0;
                end
            end
            S_RCHK: begin
                rec_we = (r_in.func != tkprs_pkg::FN_PUT) && !rec_drop;
            end
            S_PUTW: begin
                rec_we    = 1'b1;
                rec_waddr = r_base + RAW'(put_idx);
                rec_wdata = '{host: r_in.peer_host, port: r_in.peer_port,
                              created: r_in.created_ms, ttl: r_in.ttl_ms,
                              payload: r_in.payload};
                slot_we    = !r_match_ok && !rec_full;
                slot_wdata = '{vld: 1'b1, cnt: CW'(r_n + 1'b1), key: r_key};
            end
            S_SLOTW: begin
                slot_we    = (r_w != r_n);
                slot_wdata = '{vld: (r_w != '0), cnt: r_w, key: r_key};
            end
            default: begin
            end
        endcase
    end

    // Slot memory
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_waddr] <= slot_wdata;
        end
        r_slot_q <= r_slot_mem[slot_raddr];
    end

    // Record memory
    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            r_rec_mem[rec_waddr] <= rec_wdata;
        end
        r_rec_q <= r_rec_mem[rec_raddr];
    end

    // Response build
    always_comb begin
        rsp_load = 1'b0;
        rsp_data = '0;
        rsp_data.total_records = r_total;
        case (r_state)
            S_EMIT: begin
                rsp_load        = rsp_free;
                rsp_data.status = r_status;
                rsp_data.last   = 1'b1;
            end
            S_GOUT: begin
                rsp_load                = rsp_free;
                rsp_data.status         = tkprs_pkg::ST_ENTRY;
                rsp_data.out_host       = r_rec_q.host;
                rsp_data.out_port       = r_rec_q.port;
                rsp_data.out_created_ms = r_rec_q.created;
                rsp_data.out_ttl_ms     = r_rec_q.ttl;
                rsp_data.out_payload    = r_rec_q.payload;
                rsp_data.last           = (CW'(r_i + 1'b1) == r_n);
            end
            default: begin
            end
        endcase
    end

    tkprs_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (rsp_load),
        .i_data  (rsp_data),
        .o_free  (rsp_free),
        .o_rsp   (o_rsp)
    );

    // Capture the request transaction
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_sidx  <= '0;
            r_total <= '0;
            r_pv    <= 1'b0;
        end else begin
            unique case (r_state)
                // Mark every slot free
                S_CLR: begin
                    r_sidx <= SCW'(r_sidx + 1'b1);
                    if (sidx_last) begin
                        r_state <= S_IDLE;
                    end
                end
                // Take a transaction
                S_IDLE: begin
                    r_sidx    <= '0;
                    r_pv      <= 1'b0;
                    r_found   <= 1'b0;
                    r_free_ok <= 1'b0;
                    if (i_req.valid) begin
                        r_state <= (i_req.data.func == tkprs_pkg::FN_GC) ? S_CRD : S_SCAN;
                    end
                end
                // Look the key up, note the lowest free slot
                S_SCAN: begin
                    if (r_sidx < SCW'(TARGET_SLOTS)) begin
                        r_sidx <= SCW'(r_sidx + 1'b1);
                        r_pidx <= sidx_lo;
                        r_pv   <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        if (slot_hit) begin
                            r_found <= 1'b1;
                            r_slot  <= r_pidx;
                            r_n     <= r_slot_q.cnt;
                            r_state <= S_DISP;
                        end else begin
                            if (!r_slot_q.vld && !r_free_ok) begin
                                r_free_ok <= 1'b1;
                                r_free    <= r_pidx;
                            end
                            if (r_pidx == SIW'(TARGET_SLOTS - 1)) begin
                                r_state <= S_DISP;
                            end
                        end
                    end
                end
                // Dispatch on operation
                S_DISP: begin
                    r_i        <= '0;
                    r_w        <= '0;
                    r_match_ok <= 1'b0;
                    r_old      <= '0;
                    r_key      <= in_key;
                    r_base     <= base_nxt;
                    case (r_in.func)
                        tkprs_pkg::FN_PUT: begin
                            if (r_found) begin
                                r_state <= S_RRD;
                            end else if (r_free_ok) begin
                                r_slot  <= r_free;
                                r_n     <= '0;
                                r_state <= S_RRD;
                            end else begin
                                r_status <= tkprs_pkg::ST_DROPPED;
                                r_state  <= S_EMIT;
                            end
                        end
                        tkprs_pkg::FN_REMOVE: begin
                            if (r_found) begin
                                r_state <= S_RRD;
                            end else begin
                                r_status <= tkprs_pkg::ST_NOT_FOUND;
                                r_state  <= S_EMIT;
                            end
                        end
                        default: begin
                            if (r_found && (r_n != '0)) begin
                                r_state <= S_GRD;
                            end else begin
                                r_status <= tkprs_pkg::ST_EMPTY;
                                r_state  <= S_EMIT;
                            end
                        end
                    endcase
                end
                // Read the next record or finish the list
                S_RRD: begin
                    if (r_i == r_n) begin
                        r_state <= (r_in.func == tkprs_pkg::FN_PUT) ? S_PUTW : S_SLOTW;
                    end else begin
                        r_state <= S_RCHK;
                    end
                end
                // Match, track oldest, or compact
                S_RCHK: begin
                    if (r_in.func == tkprs_pkg::FN_PUT) begin
                        if (rec_match && !r_match_ok) begin
                            r_match_ok <= 1'b1;
                            r_match    <= r_i;
                        end
                        if ((r_i == '0) || (r_rec_q.created < r_old_t)) begin
                            r_old   <= r_i;
                            r_old_t <= r_rec_q.created;
                        end
                    end else if (!rec_drop) begin
                        r_w <= CW'(r_w + 1'b1);
                    end
                    r_i     <= CW'(r_i + 1'b1);
                    r_state <= S_RRD;
                end
                // Store the put record
                S_PUTW: begin
                    if (r_match_ok) begin
                        r_status <= tkprs_pkg::ST_REPLACED;
                    end else if (rec_full) begin
                        r_status <= tkprs_pkg::ST_EVICTED;
                    end else begin
                        r_status <= tkprs_pkg::ST_APPENDED;
                        r_total  <= TW'(r_total + 1'b1);
                    end
                    r_state <= S_EMIT;
                end
                // Update the slot count after compaction
                S_SLOTW: begin
                    r_total <= TW'(r_total - TW'(r_n - r_w));
                    if (r_in.func == tkprs_pkg::FN_GC) begin
                        if (sidx_last) begin
                            r_status <= tkprs_pkg::ST_GC_DONE;
                            r_state  <= S_EMIT;
                        end else begin
                            r_sidx  <= SCW'(r_sidx + 1'b1);
                            r_state <= S_CRD;
                        end
                    end else begin
                        r_status <= (r_w == r_n) ? tkprs_pkg::ST_NOT_FOUND
                                                 : tkprs_pkg::ST_REMOVED;
                        r_state  <= S_EMIT;
                    end
                end
                // Read a get record
                S_GRD: begin
                    r_state <= S_GOUT;
                end
                // Hand a get record out
                S_GOUT: begin
                    if (rsp_free) begin
                        r_i     <= CW'(r_i + 1'b1);
                        r_state <= (CW'(r_i + 1'b1) == r_n) ? S_IDLE : S_GRD;
                    end
                end
                // Read a slot for gc
                S_CRD: begin
                    r_state <= S_CCHK;
                end
                // Start compaction of a valid slot, skip a free one
                S_CCHK: begin
                    r_i <= '0;
                    r_w <= '0;
                    if (r_slot_q.vld) begin
                        r_slot  <= sidx_lo;
                        r_n     <= r_slot_q.cnt;
                        r_key   <= r_slot_q.key;
                        r_base  <= base_nxt;
                        r_state <= S_RRD;
                    end else if (sidx_last) begin
                        r_status <= tkprs_pkg::ST_GC_DONE;
                        r_state  <= S_EMIT;
                    end else begin
                        r_sidx  <= SCW'(r_sidx + 1'b1);
                        r_state <= S_CRD;
                    end
                end
                // Hand out the single result
                S_EMIT: begin
                    if (rsp_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    `TKPRS_ASSERT_CLK(a_wr_behind_rd, (r_state == S_RCHK) |-> (r_w <= r_i), "compaction write passed read")
    `TKPRS_ASSERT_CLK(a_idx_in_list, (r_state == S_RRD) |-> (r_i <= r_n), "record index beyond list")
    `TKPRS_ASSERT_CLK(a_busy_after_take, (i_req.valid && i_req.ready) |=> (r_state != S_IDLE), "transaction taken but no work started")
    `TKPRS_NEVER(a_count_bound, (r_state == S_RRD) && (r_n > CW'(PEERS_PER_TARGET)), "slot count exceeds list size")

endmodule

`default_nettype wire

// ===== rtl/tkprs_out_reg.sv =====
// ----------------------------------------------------------------------------
// tkprs_out_reg
// Response output register: holds one transaction until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tkprs_out_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire tkprs_pkg::t_rsp i_data,
    output logic                 o_free,
    tkprs_rsp_if.source          o_rsp
);

    logic            r_vld;
    tkprs_pkg::t_rsp r_data;

    // Room for a new transaction when empty or draining this cycle
    assign o_free = !r_vld || o_rsp.ready;

    // Hold valid until accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_vld <= 1'b0;
        end
    end

    // Capture payload on load
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_rsp.valid = r_vld;
    assign o_rsp.data  = r_data;

endmodule

`default_nettype wire

// ===== verif/ttl_keyed_peer_record_store_test.sv =====
// ----------------------------------------------------------------------------
// ttl_keyed_peer_record_store_test
// Drives put, remove, get and gc transactions into the keyed record store and
// checks every response against a behavioral table model held in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module ttl_keyed_peer_record_store_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 64;
    localparam int PEERS = 20;
    localparam int N_KEYS = 80;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tkprs_req_if req_ch ();
    tkprs_rsp_if rsp_ch ();

    ttl_keyed_peer_record_store #(
        .TARGET_SLOTS(SLOTS),
        .PEERS_PER_TARGET(PEERS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the table
    logic            tbl_valid [SLOTS];
    logic [255:0]    tbl_key   [SLOTS];
    int              tbl_count [SLOTS];
    tkprs_pkg::t_rec tbl_rec   [SLOTS][PEERS];

    tkprs_pkg::t_req pending_reqs[$];
    tkprs_pkg::t_rsp expected_rsps[$];
    logic [255:0] key_pool[N_KEYS];

    int errors = 0;
    int n_rsp = 0;
    int n_req = 0;

    // Append to the stimulus and expectation queues
    function automatic void add_req(tkprs_pkg::t_req q);
        pending_reqs.insert(pending_reqs.size(), q);
    endfunction

    function automatic void add_rsp(tkprs_pkg::t_rsp r);
        expected_rsps.insert(expected_rsps.size(), r);
    endfunction

    function automatic logic [10:0] table_total();
        int t;
        t = 0;
        for (int s = 0; s < SLOTS; s++) if (tbl_valid[s]) t += tbl_count[s];
        return t[10:0];
    endfunction

    function automatic tkprs_pkg::t_rsp status_rsp(logic [3:0] st);
        tkprs_pkg::t_rsp r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        r.total_records = table_total();
        return r;
    endfunction

    // Apply one request to the shadow table and queue the responses it causes
    function automatic void predict_store(tkprs_pkg::t_req q);
        logic [255:0] k;
        int slot, n, hit, w;
        tkprs_pkg::t_rec nr;
        tkprs_pkg::t_rsp r;
        k = {q.key_w3, q.key_w2, q.key_w1, q.key_w0};
        slot = -1;
        for (int s = 0; s < SLOTS; s++)
            if (slot < 0 && tbl_valid[s] && tbl_key[s] == k) slot = s;
        case (q.func)
            tkprs_pkg::FN_PUT: begin
                if (slot < 0) begin
                    for (int s = SLOTS - 1; s >= 0; s--) if (!tbl_valid[s]) slot = s;
                    if (slot < 0) begin
                        add_rsp(status_rsp(tkprs_pkg::ST_DROPPED));
                        return;
                    end
                    tbl_valid[slot] = 1'b1;
                    tbl_count[slot] = 0;
                    tbl_key[slot] = k;
                end
                nr = '{q.peer_host, q.peer_port, q.created_ms, q.ttl_ms, q.payload};
                n = tbl_count[slot];
                hit = -1;
                for (int i = 0; i < n; i++)
                    if (hit < 0 && tbl_rec[slot][i].host == q.peer_host &&
                        tbl_rec[slot][i].port == q.peer_port) hit = i;
                if (hit >= 0) begin
                    tbl_rec[slot][hit] = nr;
                    add_rsp(status_rsp(tkprs_pkg::ST_REPLACED));
                end else if (n >= PEERS) begin
                    hit = 0;
                    for (int i = 1; i < n; i++)
                        if (tbl_rec[slot][i].created < tbl_rec[slot][hit].created) hit = i;
                    tbl_rec[slot][hit] = nr;
                    add_rsp(status_rsp(tkprs_pkg::ST_EVICTED));
                end else begin
                    tbl_rec[slot][n] = nr;
                    tbl_count[slot] = n + 1;
                    add_rsp(status_rsp(tkprs_pkg::ST_APPENDED));
                end
            end
            tkprs_pkg::FN_REMOVE: begin
                if (slot < 0) begin
                    add_rsp(status_rsp(tkprs_pkg::ST_NOT_FOUND));
                    return;
                end
                n = tbl_count[slot];
                w = 0;
                for (int i = 0; i < n; i++) begin
                    if (tbl_rec[slot][i].host == q.peer_host &&
                        tbl_rec[slot][i].port == q.peer_port) continue;
                    tbl_rec[slot][w] = tbl_rec[slot][i];
                    w++;
                end
                if (w == n) begin
                    add_rsp(status_rsp(tkprs_pkg::ST_NOT_FOUND));
                end else begin
                    tbl_count[slot] = w;
                    if (w == 0) tbl_valid[slot] = 1'b0;
                    add_rsp(status_rsp(tkprs_pkg::ST_REMOVED));
                end
            end
            tkprs_pkg::FN_GET: begin
                if (slot < 0 || tbl_count[slot] == 0) begin
                    add_rsp(status_rsp(tkprs_pkg::ST_EMPTY));
                    return;
                end
                n = tbl_count[slot];
                for (int i = 0; i < n; i++) begin
                    r = status_rsp(tkprs_pkg::ST_ENTRY);
                    r.out_host = tbl_rec[slot][i].host;
                    r.out_port = tbl_rec[slot][i].port;
                    r.out_created_ms = tbl_rec[slot][i].created;
                    r.out_ttl_ms = tbl_rec[slot][i].ttl;
                    r.out_payload = tbl_rec[slot][i].payload;
                    r.last = (i == n - 1);
                    add_rsp(r);
                end
            end
            default: begin
                // Drop expired records everywhere, keep future-dated ones
                for (int s = 0; s < SLOTS; s++) begin
                    if (!tbl_valid[s]) continue;
                    w = 0;
                    for (int i = 0; i < tbl_count[s]; i++) begin
                        if (q.now_ms >= tbl_rec[s][i].created &&
                            q.now_ms - tbl_rec[s][i].created > {32'd0, tbl_rec[s][i].ttl})
                            continue;
                        tbl_rec[s][w] = tbl_rec[s][i];
                        w++;
                    end
                    tbl_count[s] = w;
                    if (w == 0) tbl_valid[s] = 1'b0;
                end
                add_rsp(status_rsp(tkprs_pkg::ST_GC_DONE));
            end
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic tkprs_pkg::t_req make_req(logic [1:0] fn, int key_idx, int peer_sel);
        tkprs_pkg::t_req q;
        q = '0;
        q.func = fn;
        {q.key_w3, q.key_w2, q.key_w1, q.key_w0} = key_pool[key_idx];
        // Small peer set so that replace and remove hit often
        q.peer_host = (peer_sel < 0) ? $urandom : 32'h0a00_0000 + peer_sel[31:0];
        q.peer_port = (peer_sel < 0) ? 16'($urandom_range(65535)) : 16'(1000 + peer_sel % 3);
        q.created_ms = $urandom_range(3) == 0 ? rand64() : 64'($urandom_range(5000));
        q.ttl_ms = $urandom_range(3) == 0 ? $urandom : $urandom_range(3000);
        q.payload = $urandom;
        q.now_ms = $urandom_range(5) == 0 ? rand64() : 64'($urandom_range(8000));
        return q;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(9) == 0) ? $urandom_range(30, 8) :
               ($urandom_range(2) == 0) ? 0 : $urandom_range(2);
    endfunction

    // Driver: present queued requests with random gaps
    int drv_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data <= '0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid) begin
                predict_store(req_ch.data);
                n_req++;
            end
            if (drv_gap > 0) begin
                drv_gap <= drv_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                req_ch.data <= pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
                drv_gap <= gap_len();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and field-by-field comparison
    always @(posedge i_clk) begin
        tkprs_pkg::t_rsp exp_r;
        tkprs_pkg::t_rsp act;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                act = rsp_ch.data;
                n_rsp++;
                if (expected_rsps.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected response %p", $realtime, act);
                end else begin
                    exp_r = expected_rsps.pop_front();
                    if (act.status !== exp_r.status || act.out_host !== exp_r.out_host ||
                        act.out_port !== exp_r.out_port ||
                        act.out_created_ms !== exp_r.out_created_ms ||
                        act.out_ttl_ms !== exp_r.out_ttl_ms ||
                        act.out_payload !== exp_r.out_payload || act.last !== exp_r.last ||
                        act.total_records !== exp_r.total_records) begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p",
                                 $realtime, exp_r, act);
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(15) == 0) ? 1'b0 :
                            ($urandom_range(3) == 0) ? 1'($urandom) : 1'b1;
        end
    end

    initial begin
        tkprs_pkg::t_req q;
        int k;
        for (int i = 0; i < N_KEYS; i++) key_pool[i] = {rand64(), rand64(), rand64(), rand64()};
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int s = 0; s < SLOTS; s++) begin
            tbl_valid[s] = 1'b0;
            tbl_count[s] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, all operations, unknown key cases
        add_req(make_req(tkprs_pkg::FN_GET, 0, 0));
        add_req(make_req(tkprs_pkg::FN_REMOVE, 0, 0));
        q = make_req(tkprs_pkg::FN_PUT, 0, 0);
        q.peer_host = '0; q.peer_port = '0; q.created_ms = '0; q.ttl_ms = '0; q.payload = '0;
        add_req(q);
        q = make_req(tkprs_pkg::FN_PUT, 1, 0);
        q.peer_host = '1; q.peer_port = '1; q.created_ms = '1; q.ttl_ms = '1; q.payload = '1;
        add_req(q);
        add_req(q);
        add_req(make_req(tkprs_pkg::FN_GET, 1, 0));
        add_req(make_req(tkprs_pkg::FN_REMOVE, 1, 5));
        // Fill key 2 past capacity to force eviction with tied creation times
        for (int i = 0; i < PEERS + 2; i++) begin
            q = make_req(tkprs_pkg::FN_PUT, 2, -1);
            q.created_ms = (i < 3) ? 64'd7 : 64'd100 + i;
            add_req(q);
        end
        add_req(make_req(tkprs_pkg::FN_GET, 2, 0));
        q = make_req(tkprs_pkg::FN_GC, 0, 0);
        q.now_ms = '1;
        add_req(q);
        q = make_req(tkprs_pkg::FN_GC, 0, 0);
        q.now_ms = '0;
        add_req(q);

        // Fill every slot with a fresh key to reach the table-full drop
        for (int i = 3; i < SLOTS + 4; i++) begin
            q = make_req(tkprs_pkg::FN_PUT, i, 1);
            q.created_ms = 64'd50; q.ttl_ms = 32'd10;
            add_req(q);
        end
        q = make_req(tkprs_pkg::FN_GC, 0, 0);
        q.now_ms = 64'd61;
        add_req(q);
        q.now_ms = 64'd100;
        add_req(q);

        // Random mix over a small key set, half of it puts
        for (int i = 0; i < 170; i++) begin
            k = $urandom_range(9) == 0 ? $urandom_range(N_KEYS - 1) : $urandom_range(7);
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: q = make_req(tkprs_pkg::FN_PUT, k,
                    $urandom_range(4) == 0 ? -1 : int'($urandom_range(24)));
                10, 11, 12: q = make_req(tkprs_pkg::FN_REMOVE, k, int'($urandom_range(24)));
                13, 14, 15, 16, 17: q = make_req(tkprs_pkg::FN_GET, k, 0);
                default: q = make_req(tkprs_pkg::FN_GC, k, 0);
            endcase
            add_req(q);
        end

        wait (pending_reqs.size() == 0 && !req_ch.valid);
        wait (expected_rsps.size() == 0);
        repeat (2000) @(posedge i_clk);
        $display("Covered %0d requests of all four operations, %0d responses checked.",
                 n_req, n_rsp);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("ttl_keyed_peer_record_store verification clean");
        else
            $display("ttl_keyed_peer_record_store verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #4ms;
        $display("ttl_keyed_peer_record_store verification failed");
        $finish;
    end
endmodule

`default_nettype wire

// ===== ttl_keyed_peer_record_store.f =====
+incdir+rtl
rtl/tkprs_pkg.sv
rtl/tkprs_if.sv
rtl/tkprs_out_reg.sv
rtl/ttl_keyed_peer_record_store.sv
verif/ttl_keyed_peer_record_store_test.sv
